/* rtl/core/moi_pkg.sv */
`default_nettype none
// ============================================================================
// moi_pkg - shared types and constants of the mecanum odometry integrator
// Sequencer states, multiplier op codes, register indexes, CORDIC table and
// the rounding and saturation helpers used by the datapath.
// ============================================================================
package moi_pkg;

    // Default iteration count of the CORDIC unit
    localparam int DEF_CORDIC_STEPS = 16;

    // Field widths
    localparam int SPEED_W  = 20;
    localparam int TICK_W   = 20;
    localparam int POSE_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // CORDIC datapath width (Q2.30 plus guard bits)
    localparam int CORDIC_W = 34;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_RECIPROCAL = 1'd1;

    // Reset values
    localparam logic [CFG_W-1:0]         WHEEL_RADIUS_RST    = 16'd4981;
    localparam logic [CFG_W-1:0]         SPAN_RECIPROCAL_RST = 16'd8192;
    localparam logic signed [POSE_W-1:0] POS_X_RST           = -32'sd242;
    localparam logic signed [POSE_W-1:0] POS_Y_RST           = -32'sd124;

    // Arithmetic constants
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [MUL_B_W-1:0]  BAM_PER_RAD     = 33'sd683565276;

    // Arctangent of 2^-i in binary angle units, full turn = 2^32
    localparam logic [31:0] ATAN_BAM [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_FLUSH,
        ST_DONE
    } moi_state_t;

    // Multiplier op sequence, issued in this order
    typedef enum logic [3:0] {
        OP_RS,   // radius times span reciprocal
        OP_VF,   // forward velocity
        OP_VS,   // side velocity
        OP_VT,   // turn rate
        OP_WX0,  // vf * cos
        OP_WX1,  // vs * sin, close world x velocity
        OP_DA,   // turn rate times tick
        OP_WY0,  // vf * sin
        OP_WY1,  // vs * cos, close world y velocity
        OP_PX,   // x step
        OP_HD,   // heading step
        OP_PY    // y step
    } moi_op_t;

    // Round to nearest, ties toward plus infinity, then shift right by n
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              n
    );
        logic signed [PROD_W-1:0] half;
        half = {{(PROD_W-1){1'b0}}, 1'b1} <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic logic signed [SPEED_W-1:0] sat_speed(
        input logic signed [PROD_W-1:0] v
    );
        if (v > 70'sd524287) begin
            return 20'sd524287;
        end else if (v < -70'sd524288) begin
            return -20'sd524288;
        end
        return $signed(v[SPEED_W-1:0]);
    endfunction

    function automatic logic signed [POSE_W-1:0] sat_pose(
        input logic signed [PROD_W-1:0] v
    );
        if (v > 70'sd2147483647) begin
            return 32'sd2147483647;
        end else if (v < -70'sd2147483648) begin
            return -32'sd2147483648;
        end
        return $signed(v[POSE_W-1:0]);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/moi_cordic.sv */
`default_nettype none
// ============================================================================
// moi_cordic - iterative CORDIC sine and cosine of a binary angle
// Folds the angle to within a quarter turn of zero, then runs one
// shift-add rotation per cycle. Results hold until the next start.
// ============================================================================
module moi_cordic
    import moi_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [31:0]                angle,
    output logic                            done,
    output logic signed [CORDIC_W-1:0]      cos_val,
    output logic signed [CORDIC_W-1:0]      sin_val
);

    localparam int CntW = (CORDIC_STEPS > 2) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(CORDIC_STEPS - 1);

    logic                       busy_reg, busy_next;
    logic [CntW-1:0]            cnt_reg, cnt_next;
    logic                       flip_reg, flip_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [CORDIC_W-1:0] z_reg, z_next;

    logic [31:0]                folded;
    logic                       fold_flip;
    logic signed [CORDIC_W-1:0] atan_step;
    logic [4:0]                 atan_idx;

    assign fold_flip = (angle + 32'h4000_0000) >= 32'h8000_0000;
    assign folded    = fold_flip ? (angle ^ 32'h8000_0000) : angle;
    assign atan_idx  = 5'(cnt_reg);
    assign atan_step = $signed({2'b00, ATAN_BAM[atan_idx]});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            // seed the rotation with the gain folded in
            busy_next = 1'b1;
            cnt_next  = '0;
            flip_next = fold_flip;
            x_next    = CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = CORDIC_W'($signed(folded));
        end else if (busy_reg) begin
            if (!z_reg[CORDIC_W-1]) begin
                x_next = x_reg - (y_reg >>> cnt_reg);
                y_next = y_reg + (x_reg >>> cnt_reg);
                z_next = z_reg - atan_step;
            end else begin
                x_next = x_reg + (y_reg >>> cnt_reg);
                y_next = y_reg - (x_reg >>> cnt_reg);
                z_next = z_reg + atan_step;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntLast) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            flip_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            flip_reg <= flip_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // last rotation happens in this cycle; results are valid from the next one
    assign done    = busy_reg && (cnt_reg == CntLast);
    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;

endmodule
`default_nettype wire

/* rtl/core/mecanum_odometry_integrator.sv */
`default_nettype none
// ============================================================================
// mecanum_odometry_integrator - mecanum wheel dead-reckoning odometry
// Forms body velocities from four wheel speeds, rotates them into the world
// frame by the stored heading and integrates pose over each control tick.
// ============================================================================
//
//  channel   dir  handshake           word layout (low bit first)
//  s_*       in   s_tvalid/s_tready   fl, fr, rl, rr speed, tick length
//  m_*       out  m_tvalid/m_tready   pose x, y, heading, fwd, side, turn
//  cfg_*     in   cfg_we              index 0 wheel radius, 1 span recip.
//
//  From acceptance until the block is ready again, one word passes through
//  the CORDIC run at one rotation per cycle, twelve ops issued through the
//  single shared multiplier, a drain state and a result-load state.
//  s_tready is high only in the idle state; a result waits in the output
//  register, so the next word is taken and worked on while it is unread.
//  A word stalls in the load cycle only if the previous result is still
//  unread. Reset (aresetn low at a clock edge) restores registers and pose.
//
module mecanum_odometry_integrator
    import moi_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // front_left_speed, front_right_speed, rear_left_speed,
    // rear_right_speed, tick_length; upper four bits zero
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [103:0]         s_tdata,

    // pose_x, pose_y, pose_heading, body_forward_vel, body_side_vel,
    // body_turn_rate; upper four bits zero
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [159:0]              m_tdata,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] radius_reg;
    logic [CFG_W-1:0] span_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= WHEEL_RADIUS_RST;
            span_reg   <= SPAN_RECIPROCAL_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WHEEL_RADIUS:    radius_reg <= cfg_wdata;
                REG_SPAN_RECIPROCAL: span_reg   <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    moi_state_t state_reg, state_next;
    moi_op_t    op_reg, op_next;
    moi_op_t    wb_op_reg;
    logic       wb_vld_reg;

    logic in_accept;
    logic cordic_start;
    logic cordic_done;
    logic issue;
    logic out_load;
    logic m_tvalid_reg;

    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_CORDIC;
            ST_CORDIC: if (cordic_done) state_next = ST_MUL;
            ST_MUL:    if (op_reg == OP_PY) state_next = ST_FLUSH;
            ST_FLUSH:  state_next = ST_DONE;
            ST_DONE:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cordic_start = 1'b0;
        issue        = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cordic_start = s_tvalid;
            end
            ST_MUL:  issue    = 1'b1;
            ST_DONE: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // advance the op counter while issuing, rewind it on acceptance
    always_comb begin
        op_next = op_reg;
        if (in_accept) begin
            op_next = OP_RS;
        end else if (issue && op_reg != OP_PY) begin
            op_next = moi_op_t'(op_reg + 4'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_RS;
            wb_vld_reg   <= 1'b0;
            wb_op_reg    <= OP_RS;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            wb_vld_reg <= issue;
            wb_op_reg  <= op_reg;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input capture
    // ------------------------------------------------------------------
    logic signed [SPEED_W:0] sum_f_reg;   // rear left + rear right
    logic signed [SPEED_W:0] sum_s_reg;   // rear left - front left
    logic signed [SPEED_W:0] dif_t_reg;   // front right - rear left
    logic [TICK_W-1:0]       dt_reg;

    logic signed [SPEED_W-1:0] in_fl, in_fr, in_rl, in_rr;

    assign in_fl = $signed(s_tdata[19:0]);
    assign in_fr = $signed(s_tdata[39:20]);
    assign in_rl = $signed(s_tdata[59:40]);
    assign in_rr = $signed(s_tdata[79:60]);

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            sum_f_reg <= 21'(in_rl) + 21'(in_rr);
            sum_s_reg <= 21'(in_rl) - 21'(in_fl);
            dif_t_reg <= 21'(in_fr) - 21'(in_rl);
            dt_reg    <= s_tdata[99:80];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC sine and cosine of the stored heading
    // ------------------------------------------------------------------
    logic [POSE_W-1:0]          hd_reg, hd_next;
    logic signed [CORDIC_W-1:0] cos_val;
    logic signed [CORDIC_W-1:0] sin_val;

    moi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (hd_reg),
        .done    (cordic_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    // ------------------------------------------------------------------
    // Shared multiplier: operands chosen by the op code, product registered
    // ------------------------------------------------------------------
    logic [31:0]                rs_reg, rs_next;
    logic signed [SPEED_W-1:0]  vf_reg, vf_next;
    logic signed [SPEED_W-1:0]  vs_reg, vs_next;
    logic signed [SPEED_W-1:0]  vt_reg, vt_next;
    logic signed [51:0]         acc_reg, acc_next;
    logic signed [MUL_A_W-1:0]  wx_reg, wx_next;
    logic signed [MUL_A_W-1:0]  wy_reg, wy_next;
    logic signed [32:0]         dtha_reg, dtha_next;
    logic signed [POSE_W-1:0]   px_reg, px_next;
    logic signed [POSE_W-1:0]   py_reg, py_next;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   wb_t;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_RS: begin
                mul_a = $signed({21'b0, radius_reg});
                mul_b = $signed({17'b0, span_reg});
            end
            OP_VF: begin
                mul_a = $signed({21'b0, radius_reg});
                mul_b = 33'(sum_f_reg);
            end
            OP_VS: begin
                mul_a = $signed({21'b0, radius_reg});
                mul_b = 33'(sum_s_reg);
            end
            OP_VT: begin
                mul_a = $signed({5'b0, rs_reg});
                mul_b = 33'(dif_t_reg);
            end
            OP_WX0: begin
                mul_a = 37'(cos_val);
                mul_b = 33'(vf_reg);
            end
            OP_WX1: begin
                mul_a = 37'(sin_val);
                mul_b = 33'(vs_reg);
            end
            OP_DA: begin
                mul_a = $signed({17'b0, dt_reg});
                mul_b = 33'(vt_reg);
            end
            OP_WY0: begin
                mul_a = 37'(sin_val);
                mul_b = 33'(vf_reg);
            end
            OP_WY1: begin
                mul_a = 37'(cos_val);
                mul_b = 33'(vs_reg);
            end
            OP_PX: begin
                mul_a = wx_reg;
                mul_b = $signed({13'b0, dt_reg});
            end
            OP_HD: begin
                mul_a = 37'(dtha_reg);
                mul_b = BAM_PER_RAD;
            end
            OP_PY: begin
                mul_a = wy_reg;
                mul_b = $signed({13'b0, dt_reg});
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Writeback: round, saturate and accumulate the previous op's product
    // ------------------------------------------------------------------
    always_comb begin
        rs_next   = rs_reg;
        vf_next   = vf_reg;
        vs_next   = vs_reg;
        vt_next   = vt_reg;
        acc_next  = acc_reg;
        wx_next   = wx_reg;
        wy_next   = wy_reg;
        dtha_next = dtha_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        hd_next   = hd_reg;
        wb_t      = '0;
        if (wb_vld_reg) begin
            case (wb_op_reg)
                OP_RS:  rs_next = prod_reg[31:0];
                OP_VF:  vf_next = sat_speed(rnd_shift(prod_reg, 17));
                OP_VS:  vs_next = sat_speed(rnd_shift(prod_reg, 17));
                OP_VT:  vt_next = sat_speed(rnd_shift(prod_reg, 40));
                OP_WX0: acc_next = prod_reg[51:0];
                OP_WX1: begin
                    wb_t    = rnd_shift(70'(acc_reg) - prod_reg, 14);
                    wx_next = wb_t[MUL_A_W-1:0];
                end
                OP_DA: begin
                    wb_t      = rnd_shift(prod_reg, 8);
                    dtha_next = wb_t[32:0];
                end
                OP_WY0: acc_next = prod_reg[51:0];
                OP_WY1: begin
                    wb_t    = rnd_shift(70'(acc_reg) + prod_reg, 14);
                    wy_next = wb_t[MUL_A_W-1:0];
                end
                OP_PX:  px_next = sat_pose(70'(px_reg) + rnd_shift(prod_reg, 32));
                OP_HD: begin
                    // wrap the heading once per turn
                    wb_t    = rnd_shift(prod_reg, 24);
                    hd_next = hd_reg + wb_t[POSE_W-1:0];
                end
                OP_PY:  py_next = sat_pose(70'(py_reg) + rnd_shift(prod_reg, 32));
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg <= POS_X_RST;
            py_reg <= POS_Y_RST;
            hd_reg <= '0;
        end else begin
            px_reg <= px_next;
            py_reg <= py_next;
            hd_reg <= hd_next;
        end
        rs_reg   <= rs_next;
        vf_reg   <= vf_next;
        vs_reg   <= vs_next;
        vt_reg   <= vt_next;
        acc_reg  <= acc_next;
        wx_reg   <= wx_next;
        wy_reg   <= wy_next;
        dtha_reg <= dtha_next;
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until it is taken
    // ------------------------------------------------------------------
    logic [159:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {4'b0, vt_reg, vs_reg, vf_reg, hd_reg, py_reg, px_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_wb_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_vld_reg |-> (state_reg == ST_MUL || state_reg == ST_FLUSH))
        else $error("writeback outside the multiply phase");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == ST_CORDIC))
        else $error("accepted word did not start the CORDIC run");

    a_done_in_cordic: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == ST_CORDIC))
        else $error("CORDIC finished outside its phase");

    a_valid_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a load");

endmodule
`default_nettype wire
